### rtl/vctf_pkg.sv
// ----------------------------------------------------------------------------
// vctf_pkg: shared types and codes for the component to float converter
// Component kind codes, register indexes and the stage payload structs.
// ----------------------------------------------------------------------------
package vctf_pkg;

  // component kinds
  localparam logic [2:0] KIND_SBYTE  = 3'd0;
  localparam logic [2:0] KIND_UBYTE  = 3'd1;
  localparam logic [2:0] KIND_SSHORT = 3'd2;
  localparam logic [2:0] KIND_USHORT = 3'd3;
  localparam logic [2:0] KIND_UINT32 = 3'd4;
  localparam logic [2:0] KIND_FLOAT  = 3'd5;

  // register indexes
  localparam logic REG_KIND = 1'b0;
  localparam logic REG_NORM = 1'b1;

  localparam logic [31:0] FLT_NEG_ONE = 32'hBF80_0000;
  localparam logic [31:0] FLT_ZERO    = 32'h0000_0000;

  // stage 1 -> stage 2
  typedef struct packed {
    logic        byp;       // result fixed at decode
    logic [31:0] byp_bits;
    logic        sign;
    logic [63:0] frac;      // bit string to normalise
    logic        xstk;      // ones lie beyond the string
    logic        nrm;       // fraction scaling (value = 0.frac)
  } vctf_dec_t;

  // stage 2 -> stage 3
  typedef struct packed {
    vctf_dec_t  d;
    logic       zero;
    logic [5:0] lz;
  } vctf_lzc_t;

endpackage

### rtl/vctf_decode.sv
// ----------------------------------------------------------------------------
// vctf_decode: first stage, picks the component apart
// Builds sign, magnitude string and bypass result for the selected kind.
// A normalised n-bit value m/(2^n-1) is the pattern m repeated forever.
// ----------------------------------------------------------------------------
module vctf_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_ok,
  input  logic [31:0]          raw_component,
  input  logic [2:0]           kind,
  input  logic                 norm,
  output logic                 vld,
  output vctf_pkg::vctf_dec_t  dout
);

  vctf_pkg::vctf_dec_t d_next;
  logic [7:0]  mag8;
  logic [15:0] mag16;
  logic [69:0] rep7;
  logic [74:0] rep15;

  always_comb begin
    mag8  = raw_component[7]  ? (8'd0 - raw_component[7:0])   : raw_component[7:0];
    mag16 = raw_component[15] ? (16'd0 - raw_component[15:0]) : raw_component[15:0];
    rep7  = {10{mag8[6:0]}};
    rep15 = {5{mag16[14:0]}};
  end

  // kind decode
  always_comb begin
    d_next.byp      = 1'b0;
    d_next.byp_bits = vctf_pkg::FLT_ZERO;
    d_next.sign     = 1'b0;
    d_next.frac     = 64'd0;
    d_next.xstk     = 1'b0;
    d_next.nrm      = 1'b0;
    case (kind)
      vctf_pkg::KIND_SBYTE: begin
        d_next.sign = raw_component[7];
        if (norm) begin
          d_next.nrm = 1'b1;
          if (raw_component[7:0] == 8'h80) begin
            d_next.byp      = 1'b1;
            d_next.byp_bits = vctf_pkg::FLT_NEG_ONE;
          end else begin
            d_next.frac = rep7[69:6];
            d_next.xstk = |mag8;
          end
        end else begin
          d_next.frac = {24'd0, mag8, 32'd0};
        end
      end
      vctf_pkg::KIND_UBYTE: begin
        if (norm) begin
          d_next.nrm  = 1'b1;
          d_next.frac = {8{raw_component[7:0]}};
          d_next.xstk = |raw_component[7:0];
        end else begin
          d_next.frac = {24'd0, raw_component[7:0], 32'd0};
        end
      end
      vctf_pkg::KIND_SSHORT: begin
        d_next.sign = raw_component[15];
        if (norm) begin
          d_next.nrm = 1'b1;
          if (raw_component[15:0] == 16'h8000) begin
            d_next.byp      = 1'b1;
            d_next.byp_bits = vctf_pkg::FLT_NEG_ONE;
          end else begin
            d_next.frac = rep15[74:11];
            d_next.xstk = |mag16;
          end
        end else begin
          d_next.frac = {16'd0, mag16, 32'd0};
        end
      end
      vctf_pkg::KIND_USHORT: begin
        if (norm) begin
          d_next.nrm  = 1'b1;
          d_next.frac = {4{raw_component[15:0]}};
          d_next.xstk = |raw_component[15:0];
        end else begin
          d_next.frac = {16'd0, raw_component[15:0], 32'd0};
        end
      end
      vctf_pkg::KIND_UINT32: begin
        d_next.frac = {raw_component, 32'd0};
      end
      vctf_pkg::KIND_FLOAT: begin
        d_next.byp      = 1'b1;
        d_next.byp_bits = raw_component;
      end
      default: begin
        d_next.byp      = 1'b1;
        d_next.byp_bits = vctf_pkg::FLT_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= in_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= d_next;
    end
  end

endmodule

### rtl/vctf_lzc.sv
// ----------------------------------------------------------------------------
// vctf_lzc: second stage, leading zero count
// Counts leading zeros of the 64-bit string and flags an all-zero value.
// ----------------------------------------------------------------------------
module vctf_lzc (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 vld_in,
  input  vctf_pkg::vctf_dec_t  din,
  output logic                 vld,
  output vctf_pkg::vctf_lzc_t  dout
);

  logic [5:0] lz_next;

  // priority encode, highest set bit wins
  always_comb begin
    lz_next = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (din.frac[i]) lz_next = 6'(63 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout.d    <= din;
      dout.zero <= ~|din.frac;
      dout.lz   <= lz_next;
    end
  end

endmodule

### rtl/vctf_round.sv
// ----------------------------------------------------------------------------
// vctf_round: third and fourth stages, normalise, round and pack
// Stage 3 shifts the leading one to the top and splits mantissa, guard
// and sticky; stage 4 rounds to nearest even and holds the output beat.
// ----------------------------------------------------------------------------
module vctf_round (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 vld_in,
  input  vctf_pkg::vctf_lzc_t  din,
  output logic                 vld,
  output logic [31:0]          float_bits
);

  logic [63:0] sh;
  logic [7:0]  exp_next;

  // stage 3 registers
  logic        v3;
  logic        byp3;
  logic [31:0] byp_bits3;
  logic        zero3;
  logic        sign3;
  logic [7:0]  exp3;
  logic [22:0] mant3;
  logic        g3;
  logic        st3;

  logic        up;
  logic [30:0] mag_rnd;

  always_comb begin
    sh       = din.d.frac << din.lz;
    exp_next = din.d.nrm ? (8'd126 - {2'd0, din.lz}) : (8'd158 - {2'd0, din.lz});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byp3      <= din.d.byp;
      byp_bits3 <= din.d.byp_bits;
      zero3     <= din.zero;
      sign3     <= din.d.sign;
      exp3      <= exp_next;
      mant3     <= sh[62:40];
      g3        <= sh[39];
      st3       <= (|sh[38:0]) | din.d.xstk;
    end
  end

  // round to nearest even; a carry out of the mantissa bumps the exponent
  always_comb begin
    up      = g3 & (st3 | mant3[0]);
    mag_rnd = {exp3, mant3} + {30'd0, up};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (byp3) begin
        float_bits <= byp_bits3;
      end else if (zero3) begin
        float_bits <= vctf_pkg::FLT_ZERO;
      end else begin
        float_bits <= {sign3, mag_rnd};
      end
    end
  end

endmodule

### rtl/vertex_component_to_float_core.sv
// ----------------------------------------------------------------------------
// vertex_component_to_float_core: vertex component to single-precision float
// Four-stage pipeline converting one raw attribute component per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: raw_component with in_valid / in_stall. A beat is taken
//   when in_valid is high and in_stall is low.
//   Output channel: float_bits with out_valid / out_stall, one result beat
//   for every input beat, in order.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 component kind, 1 normalise enable); write only while idle.
//   An input beat reaches output valid through the registers of decode,
//   leading zero count, normalise shift, and round and output register.
//   Throughput is one beat per cycle unless out_stall holds a result; every
//   stage is a register stage and the whole pipe moves together.
//   When the receiver stalls with a result waiting, the pipe freezes and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset (rst, synchronous) empties the pipe and returns the registers to
//   float pass-through with normalisation off.
// ----------------------------------------------------------------------------
module vertex_component_to_float_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] raw_component,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] float_bits,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);

  logic [2:0] component_kind;
  logic       normalize_enable;
  logic       adv;
  logic       v1;
  logic       v2;
  vctf_pkg::vctf_dec_t s1;
  vctf_pkg::vctf_lzc_t s2;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      component_kind   <= vctf_pkg::KIND_FLOAT;
      normalize_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        vctf_pkg::REG_KIND: component_kind   <= cfg_data;
        vctf_pkg::REG_NORM: normalize_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // whole pipe advances unless a finished beat is held back
  assign adv      = ~out_valid | ~out_stall;
  assign in_stall = ~adv;

  vctf_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_ok         (in_valid),
    .raw_component (raw_component),
    .kind          (component_kind),
    .norm          (normalize_enable),
    .vld           (v1),
    .dout          (s1)
  );

  vctf_lzc u_lzc (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .vld_in (v1),
    .din    (s1),
    .vld    (v2),
    .dout   (s2)
  );

  vctf_round u_round (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .vld_in     (v2),
    .din        (s2),
    .vld        (out_valid),
    .float_bits (float_bits)
  );

endmodule

### rtl/vctf_checker.sv
// ----------------------------------------------------------------------------
// vctf_checker: port-level checks for the converter
// Watches the handshakes of the top level and flags slips over time.
// ----------------------------------------------------------------------------
module vctf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] float_bits
);

  // a held result beat stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped under stall");

  // and keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(float_bits))
    else $error("output beat changed under stall");

  // input side only backs up when a result is held
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind vertex_component_to_float_core vctf_checker u_vctf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .float_bits (float_bits)
);

### sim/vctf_checker.sv
// ----------------------------------------------------------------------------
// vctf_scoreboard: result checker for the component to float converter
// Tracks the register writes, predicts every accepted input beat and checks
// the result beats in order against the predicted float bit patterns.
// ----------------------------------------------------------------------------
module vctf_scoreboard (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] raw_component,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] float_bits,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [2:0]  kind_shadow;
  logic        norm_shadow;
  logic [31:0] expected_floats[$];

  // Round a double to single precision, nearest even; values here are
  // always zero or normal, so no subnormal or overflow handling is needed.
  function automatic logic [31:0] to_single(real r);
    logic [63:0] d;
    logic [24:0] m;
    logic [10:0] e;
    logic        up;
    d = $realtobits(r);
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    m  = {2'b01, d[51:29]};
    up = d[28] && ((|d[27:0]) || m[0]);
    m  = m + {24'd0, up};
    e  = d[62:52] - 11'd1023 + 11'd127;
    if (m[24]) begin
      m = m >> 1;
      e = e + 11'd1;
    end
    return {d[63], e[7:0], m[22:0]};
  endfunction

  // Division in double then one rounding to single is correctly rounded.
  function automatic logic [31:0] scaled(real v, real div, bit clamp);
    real q;
    q = v / div;
    if (clamp && q < -1.0) return vctf_pkg::FLT_NEG_ONE;
    return to_single(q);
  endfunction

  function automatic logic [31:0] convert_component(logic [31:0] raw, logic [2:0] kind,
                                                    logic nrm);
    real v;
    case (kind)
      vctf_pkg::KIND_SBYTE: begin
        v = $signed(raw[7:0]);
        return nrm ? scaled(v, 127.0, 1'b1) : to_single(v);
      end
      vctf_pkg::KIND_UBYTE: begin
        v = raw[7:0];
        return nrm ? scaled(v, 255.0, 1'b0) : to_single(v);
      end
      vctf_pkg::KIND_SSHORT: begin
        v = $signed(raw[15:0]);
        return nrm ? scaled(v, 32767.0, 1'b1) : to_single(v);
      end
      vctf_pkg::KIND_USHORT: begin
        v = raw[15:0];
        return nrm ? scaled(v, 65535.0, 1'b0) : to_single(v);
      end
      vctf_pkg::KIND_UINT32: begin
        v = raw;
        return to_single(v);
      end
      vctf_pkg::KIND_FLOAT: return raw;
      default:              return vctf_pkg::FLT_ZERO;
    endcase
  endfunction

  assign pending = expected_floats.size();

  always @(posedge clk) begin
    if (rst) begin
      kind_shadow = vctf_pkg::KIND_FLOAT;
      norm_shadow = 1'b0;
      expected_floats.delete();
      errors = 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_floats.size() == 0) begin
          $error("float_bits: unexpected beat %h", float_bits);
          errors++;
        end else begin
          logic [31:0] want;
          want = expected_floats.pop_front();
          if (float_bits !== want) begin
            $error("float_bits: expected %h actual %h", want, float_bits);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_floats = {expected_floats,
                           convert_component(raw_component, kind_shadow, norm_shadow)};
      if (cfg_we) begin
        if (cfg_index == vctf_pkg::REG_KIND) kind_shadow = cfg_data;
        else norm_shadow = cfg_data[0];
      end
    end
  end
endmodule

### sim/vertex_component_to_float_core_tb.sv
// ----------------------------------------------------------------------------
// vertex_component_to_float_core_tb: testbench for the component converter
// Steps through every kind code with normalisation off and on, sending edge
// values (kinds 0 to 5 only) then random components under random gaps and output stalls.
// ----------------------------------------------------------------------------
module vertex_component_to_float_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PER_SETTING = 25;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] raw_component = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] float_bits;
  logic        cfg_we = 1'b0;
  logic        cfg_index = vctf_pkg::REG_KIND;
  logic [2:0]  cfg_data = '0;
  int          errors;
  int          pending;
  int          quiet_cycles = 0;
  int          beats_sent = 0;
  bit          no_gaps = 0;
  bit          stall_heavy = 0;

  always #5 clk = ~clk;

  vertex_component_to_float_core dut (.*);
  vctf_scoreboard checker_i (.*);

  // watchdog: cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int gap_len();
    if (no_gaps) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 30);
  endfunction

  // receiver stall, mostly short
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (stall_heavy) out_stall <= ($urandom_range(0, 3) != 0);
    else if (no_gaps) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 9) < 3);
  end

  // valid stays up across back-to-back beats and drops only for a gap
  task automatic send_beat(logic [31:0] value);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid      <= 1'b1;
    raw_component <= value;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic write_reg(logic idx, logic [2:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] random_component();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 255) | ($urandom() & 32'hFFFF_FF00);
      1:       return $urandom_range(0, 65535) | ($urandom() & 32'hFFFF_0000);
      2:       return $urandom_range(0, 3) == 0 ? 32'h7F80_0000 | $urandom() : $urandom();
      3:       return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] edges[6];
    edges = '{32'h0000_0000, 32'hFFFF_FF80, 32'h0000_007F, 32'h0000_8000,
              32'h7FFF_FFFF, 32'hFFFF_FFFF};
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset state: float pass-through, NaN payload included
    send_beat(32'h7FC0_1234);
    send_beat(32'h8000_0000);

    for (int setting = 0; setting < 16; setting++) begin
      write_reg(vctf_pkg::REG_KIND, 3'(setting >> 1));
      write_reg(vctf_pkg::REG_NORM, 3'(setting & 1));
      no_gaps     = (setting % 5 == 2);
      stall_heavy = (setting % 5 == 4);
      if (setting < 12)
        foreach (edges[i]) if ((i + setting) % 3 == 0) send_beat(edges[i]);
      for (int n = 0; n < RANDOM_PER_SETTING; n++) send_beat(random_component());
    end

    in_valid <= 1'b0;
    no_gaps = 1;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Sent %0d components over all kind codes, normalisation off and on,",
             beats_sent);
    $display("with random input gaps and output stalls.");
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

### filelist.f
rtl/vctf_pkg.sv
rtl/vctf_decode.sv
rtl/vctf_lzc.sv
rtl/vctf_round.sv
rtl/vertex_component_to_float_core.sv
rtl/vctf_checker.sv
sim/vctf_checker.sv
sim/vertex_component_to_float_core_tb.sv
